// ----- rtl/irtx_pkg.sv -----
package irtx_pkg;

    // Field widths of the frame and of the carrier settings.
    localparam int unsigned ADDR_W   = 8;
    localparam int unsigned CODE_W   = 6;
    localparam int unsigned PWR_W    = 4;
    localparam int unsigned PERIOD_W = 7;
    localparam int unsigned DUTY_W   = 6;
    localparam int unsigned COUNT_W  = 4;

    // Slots sent for each field, most significant bit first.
    localparam logic [COUNT_W-1:0] ADDR_SLOTS = 4'd8;
    localparam logic [COUNT_W-1:0] CMD_SLOTS  = 4'd6;
    localparam logic [COUNT_W-1:0] PWR_SLOTS  = 4'd6;

    localparam logic [PERIOD_W-1:0] PERIOD_BASE = 7'd33;
    localparam logic [PERIOD_W-1:0] PERIOD_TOP  = 7'd65;
    localparam logic [ADDR_W-1:0]   ADDR_RESET  = 8'd10;

    // Power levels that steer the step taken at each header.
    localparam logic [PWR_W-1:0] PWR_STEP_LIMIT = 4'd8;
    localparam logic [PWR_W-1:0] PWR_HIGH_FLOOR = 4'd7;
    localparam logic [PWR_W-1:0] PWR_WRAP_AT    = 4'd10;
    localparam logic [PWR_W-1:0] PWR_WRAP_TO    = 4'd1;

    typedef struct packed {
        logic              send_request;
        logic [CODE_W-1:0] command_code;
    } t_in_item;

    typedef struct packed {
        logic                carrier_on;
        logic                long_slot;
        logic [PERIOD_W-1:0] carrier_period;
        logic [DUTY_W-1:0]   carrier_duty;
        logic                frame_done;
        logic                busy_res;
    } t_out_item;

endpackage

// ----- rtl/ir_remote_frame_transmitter.sv -----
// The result of a request is registered as the request is accepted.
// Throughput: one request per cycle when not stalled; each request is one slot
// tick, settled by one pass of frame logic between state and output registers.
// A two-entry output stage (output register plus skid register) keeps the input
// open for one more request while a result waits downstream.
// Reset (i_rst_n low, synchronous): idle, power level 0, period 33, address 10.
module ir_remote_frame_transmitter
    import irtx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration: remote address register
    input  logic                i_cfg_we,
    input  logic [ADDR_W-1:0]   i_cfg_wdata,
    // Slot tick requests
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_data,
    // Slot results
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_data
);

    // Frame sequencer phase codes. The unused code behaves as idle.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_ADDR  = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd2;
    localparam logic [2:0] PH_PWR   = 3'd3;
    localparam logic [2:0] PH_STOP1 = 3'd4;
    localparam logic [2:0] PH_STOP2 = 3'd5;
    localparam logic [2:0] PH_END   = 3'd6;

    logic [ADDR_W-1:0]   r_addr;
    logic [2:0]          r_phase,     n_phase;
    logic [COUNT_W-1:0]  r_bits_left, n_bits_left;
    logic [PWR_W-1:0]    r_power,     n_power;
    logic [PERIOD_W-1:0] r_period,    n_period;
    logic [CODE_W-1:0]   r_code,      n_code;

    logic                r_out_valid;
    t_out_item           r_out_data;
    logic                r_skid_valid;
    t_out_item           r_skid_data;

    t_out_item           result;
    logic                in_accept;
    logic                out_take;
    logic                out_free;

    // Picks one bit of a field word; positions past the word read as zero.
    function automatic logic pick_bit(input logic [ADDR_W-1:0] word,
                                      input logic [COUNT_W-1:0] idx);
        logic b;
        b = 1'b0;
        if (idx < COUNT_W'(ADDR_W)) begin
            b = word[idx[2:0]];
        end
        return b;
    endfunction

    // The skid register holds at most one result, so the input stalls only
    // once both output entries are occupied.
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid & ~r_skid_valid;
    assign out_take    = r_out_valid & ~i_out_stall;
    assign out_free    = ~r_out_valid | out_take;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // One slot tick of the frame sequencer.
    always_comb begin
        logic [ADDR_W-1:0]   word;
        logic [COUNT_W-1:0]  bl_dec;
        logic [2:0]          after_phase;
        logic [COUNT_W-1:0]  after_count;
        logic                on;
        logic                long_s;
        logic                done;
        logic                busy;
        logic                is_field;

        n_phase     = r_phase;
        n_bits_left = r_bits_left;
        n_power     = r_power;
        n_period    = r_period;
        n_code      = r_code;
        on          = 1'b0;
        long_s      = 1'b0;
        done        = 1'b0;
        busy        = 1'b1;
        is_field    = 1'b0;
        word        = '0;
        after_phase = PH_IDLE;
        after_count = '0;

        case (r_phase)
            PH_ADDR: begin
                is_field    = 1'b1;
                word        = r_addr;
                after_phase = PH_CMD;
                after_count = CMD_SLOTS;
            end
            PH_CMD: begin
                is_field    = 1'b1;
                word        = ADDR_W'(r_code);
                after_phase = PH_PWR;
                after_count = PWR_SLOTS;
            end
            PH_PWR: begin
                is_field    = 1'b1;
                word        = ADDR_W'(r_power);
                after_phase = PH_STOP1;
                after_count = '0;
            end
            PH_STOP1: begin
                on      = 1'b1;
                n_phase = PH_STOP2;
            end
            PH_STOP2: begin
                on      = 1'b1;
                n_phase = PH_END;
            end
            PH_END: begin
                done    = 1'b1;
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_in_data.send_request) begin
                    n_code = i_in_data.command_code;
                    // Power step: climb with the period, jump to the top
                    // period above seven, wrap back to the base at ten.
                    if (n_power < PWR_STEP_LIMIT) begin
                        n_power  = n_power + 1'b1;
                        n_period = n_period + 1'b1;
                    end
                    if (n_power > PWR_HIGH_FLOOR) begin
                        n_power  = n_power + 1'b1;
                        n_period = PERIOD_TOP;
                    end
                    if (n_power == PWR_WRAP_AT) begin
                        n_power  = PWR_WRAP_TO;
                        n_period = PERIOD_BASE;
                    end
                    on          = 1'b1;
                    long_s      = 1'b1;
                    n_phase     = PH_ADDR;
                    n_bits_left = ADDR_SLOTS;
                end else begin
                    busy = 1'b0;
                end
            end
        endcase

        // Shared field shifter: count down, send that bit, move on at zero.
        bl_dec = (r_bits_left != '0) ? r_bits_left - 1'b1 : '0;
        if (is_field) begin
            on          = pick_bit(word, bl_dec);
            n_bits_left = bl_dec;
            if (bl_dec == '0) begin
                n_phase     = after_phase;
                n_bits_left = after_count;
            end
        end

        result.carrier_on     = on;
        result.long_slot      = long_s;
        result.carrier_period = n_period;
        result.carrier_duty   = n_period[PERIOD_W-1:1];
        result.frame_done     = done;
        result.busy_res       = busy;
    end

    // Sequencer state advances only on an accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= ADDR_RESET;
            r_phase     <= PH_IDLE;
            r_bits_left <= '0;
            r_power     <= '0;
            r_period    <= PERIOD_BASE;
            r_code      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_addr <= i_cfg_wdata;
            end
            if (in_accept) begin
                r_phase     <= n_phase;
                r_bits_left <= n_bits_left;
                r_power     <= n_power;
                r_period    <= n_period;
                r_code      <= n_code;
            end
        end
    end

    // Output register and skid register valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid | in_accept;
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload: the skid entry is older, so it moves to the output first.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (in_accept) begin
                r_out_data <= result;
            end
        end else if (in_accept) begin
            r_skid_data <= result;
        end
    end

endmodule

// ----- rtl/irtx_checker.sv -----
module irtx_checker
    import irtx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_stall,
    input  t_in_item          i_in_data,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  t_out_item         o_out_data
);

    // The closing slot of a frame is silent and still counts as busy.
    a_done_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_done) |->
            (o_out_data.busy_res && !o_out_data.carrier_on && !o_out_data.long_slot))
        else $error("frame end slot has wrong flags");

    // The header slot always carries the carrier and opens a frame.
    a_header_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.long_slot) |->
            (o_out_data.carrier_on && o_out_data.busy_res))
        else $error("header slot has wrong flags");

    // Duty is half the period, and the period stays in its legal band.
    a_carrier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_data.carrier_duty == o_out_data.carrier_period[PERIOD_W-1:1]) &&
             (o_out_data.carrier_period >= PERIOD_BASE) &&
             (o_out_data.carrier_period <= PERIOD_TOP)))
        else $error("carrier period or duty out of line");

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // A stalled request stays offered and unchanged until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_data)))
        else $error("stalled request changed");

endmodule

bind ir_remote_frame_transmitter irtx_checker u_irtx_checker (.*);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the infrared remote frame transmitter. Every request is
// one slot tick; each accepted tick is run through an independent model of the frame
// sequencer and the slot it should produce is queued. A checker pops that queue on
// every accepted result and compares the fields one by one. Traffic starts with a few
// hand-picked ticks, then long random runs under changing idle patterns and remote
// addresses, with one long output hold-off that fills the block and stalls its input.
module tb_top;
    import irtx_pkg::*;

    // Frame position as the model tracks it.
    typedef enum logic [2:0] {
        FRAME_IDLE,
        FRAME_ADDR,
        FRAME_CMD,
        FRAME_PWR,
        FRAME_STOP1,
        FRAME_STOP2,
        FRAME_END
    } frame_phase_e;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [ADDR_W-1:0] i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_item         o_out_data;

    // Model state, mirroring the registers of the sequencer.
    frame_phase_e         frame_phase;
    logic [COUNT_W-1:0]   slots_left;
    logic [PWR_W-1:0]     power_level;
    logic [PERIOD_W-1:0]  period_model;
    logic [CODE_W-1:0]    code_latched;
    logic [ADDR_W-1:0]    address_model;

    // Slots that the block still owes us, oldest first.
    t_out_item slots_due[$];
    int        mismatches = 0;

    // Idle behaviour of either side, in percent, and the length of a forced hold-off.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    ir_remote_frame_transmitter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The power level climbs by one per header until it reaches the high band, where
    // it jumps past eight with the period forced to its top value; one more header
    // wraps it back to level one and the base period.
    function automatic void step_power_level();
        if (power_level < PWR_STEP_LIMIT) begin
            power_level  = power_level + 1'b1;
            period_model = period_model + 1'b1;
        end
        if (power_level > PWR_HIGH_FLOOR) begin
            power_level  = power_level + 1'b1;
            period_model = PERIOD_TOP;
        end
        if (power_level == PWR_WRAP_AT) begin
            power_level  = PWR_WRAP_TO;
            period_model = PERIOD_BASE;
        end
    endfunction

    // Sends the next bit of a field, most significant first, and moves on to the
    // following field once the count runs out.
    function automatic logic shift_next_bit(input logic [ADDR_W-1:0] word,
                                            input frame_phase_e after,
                                            input logic [COUNT_W-1:0] reload);
        logic [ADDR_W-1:0] shifted;
        if (slots_left != '0)
            slots_left = slots_left - 1'b1;
        shifted = word >> slots_left;
        if (slots_left == '0) begin
            frame_phase = after;
            slots_left  = reload;
        end
        return shifted[0];
    endfunction

    // Works out the slot that one accepted tick must produce and advances the model.
    function automatic t_out_item advance_frame(input t_in_item tick);
        t_out_item slot;
        slot          = '0;
        slot.busy_res = 1'b1;
        case (frame_phase)
            FRAME_ADDR: begin
                // The address is read live, so a write part-way through a frame
                // shows up in the remaining address slots.
                slot.carrier_on = shift_next_bit(address_model, FRAME_CMD, CMD_SLOTS);
            end
            FRAME_CMD: begin
                slot.carrier_on = shift_next_bit({2'b00, code_latched}, FRAME_PWR,
                                                 PWR_SLOTS);
            end
            FRAME_PWR: begin
                slot.carrier_on = shift_next_bit({4'b0000, power_level}, FRAME_STOP1,
                                                 '0);
            end
            FRAME_STOP1: begin
                slot.carrier_on = 1'b1;
                frame_phase     = FRAME_STOP2;
            end
            FRAME_STOP2: begin
                slot.carrier_on = 1'b1;
                frame_phase     = FRAME_END;
            end
            FRAME_END: begin
                slot.frame_done = 1'b1;
                frame_phase     = FRAME_IDLE;
            end
            default: begin
                // Only an idle tick looks at the request; during a frame it is ignored.
                frame_phase = FRAME_IDLE;
                if (tick.send_request) begin
                    code_latched = tick.command_code;
                    step_power_level();
                    slot.carrier_on = 1'b1;
                    slot.long_slot  = 1'b1;
                    frame_phase     = FRAME_ADDR;
                    slots_left      = ADDR_SLOTS;
                end else begin
                    slot.busy_res = 1'b0;
                end
            end
        endcase
        slot.carrier_period = period_model;
        slot.carrier_duty   = period_model[PERIOD_W-1:1];
        return slot;
    endfunction

    // Offers one tick as a request and waits until the block takes it. The sender may
    // idle first; once valid is raised the payload is held until acceptance.
    task automatic send_tick(input logic request, input logic [CODE_W-1:0] code);
        t_in_item tick;
        tick.send_request = request;
        tick.command_code = code;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = tick;
        do
            @(posedge i_clk);
        while (o_in_stall);
        slots_due.push_back(advance_frame(tick));
    endtask

    // Stops offering requests and waits for every owed slot, then keeps waiting in case
    // anything unexpected is still on its way out.
    task automatic drain_results();
        int waited;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        for (waited = 0; waited < 4000 && slots_due.size() != 0; waited++)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the remote address once the block has nothing in flight.
    task automatic write_address(input logic [ADDR_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we      = 1'b0;
        address_model = value;
    endtask

    // Idle percentages are changed on the rising edge, away from the falling edge at
    // which the driving processes read them.
    task automatic set_idling(input int sender_pct, input int receiver_pct);
        @(posedge i_clk);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // Idle ticks without a request must leave the carrier off and show the base period.
    task automatic test_idle_ticks();
        send_tick(1'b0, '1);
        send_tick(1'b0, '0);
    endtask

    // One full frame at the reset address with the largest command. Requests are high
    // over four address slots, then every other tick; every one after the header must
    // be ignored. The address is rewritten after those slots to show it is read live.
    task automatic test_frame_with_address_change();
        int n;
        send_tick(1'b1, '1);
        for (n = 0; n < 4; n++)
            send_tick(1'b1, '0);
        write_address('1);
        for (n = 0; n < 19; n++)
            send_tick(n[0], n[5:0]);
        send_tick(1'b0, '1);
    endtask

    // Random slot ticks. Most ticks carry a request so that frames follow each other
    // closely; the command leans towards its extremes now and then.
    task automatic test_random_traffic(input int count, input int sender_pct,
                                       input int receiver_pct,
                                       input logic [ADDR_W-1:0] address);
        int n;
        logic [CODE_W-1:0] code;
        write_address(address);
        set_idling(sender_pct, receiver_pct);
        for (n = 0; n < count; n++) begin
            case ($urandom_range(7))
                0: code = '0;
                1: code = '1;
                default: code = CODE_W'($urandom_range(63));
            endcase
            send_tick($urandom_range(3) != 0, code);
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // requests, so the output stage fills and the block has to stall its input.
    task automatic test_output_backpressure();
        int n;
        drain_results();
        set_idling(0, 0);
        @(posedge i_clk);
        hold_left = 150;
        for (n = 0; n < 40; n++)
            send_tick(1'b1, CODE_W'($urandom_range(63)));
    endtask

    // Receiver: a forced hold-off has priority, otherwise it stalls at random.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall = 1'b1;
            hold_left   = hold_left - 1;
        end else begin
            i_out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Checker: every accepted result must match the oldest owed slot.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (slots_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no slot owed: %p", $realtime, o_out_data);
            end else begin
                want = slots_due.pop_front();
                if (o_out_data.carrier_on !== want.carrier_on ||
                    o_out_data.long_slot !== want.long_slot ||
                    o_out_data.carrier_period !== want.carrier_period ||
                    o_out_data.carrier_duty !== want.carrier_duty ||
                    o_out_data.frame_done !== want.frame_done ||
                    o_out_data.busy_res !== want.busy_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: slot mismatch, expected %p, got %p",
                                 $realtime, want, o_out_data);
                end
            end
        end
    end

    initial begin
        // Model and inputs start from the reset state before the clock runs.
        frame_phase   = FRAME_IDLE;
        slots_left    = '0;
        power_level   = '0;
        period_model  = PERIOD_BASE;
        code_latched  = '0;
        address_model = ADDR_RESET;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_stall   = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        set_idling(12, 51);
        test_idle_ticks();
        test_frame_with_address_change();
        test_random_traffic(550, 12, 51, '0);
        test_output_backpressure();
        test_random_traffic(550, 51, 12, '1);
        test_random_traffic(550, 0, 0, ADDR_W'($urandom_range(255)));
        drain_results();

        if (slots_due.size() != 0) begin
            mismatches += slots_due.size();
            $display("%0d owed slots never arrived", slots_due.size());
        end
        if (mismatches == 0) begin
            $display("PASS ir_remote_frame_transmitter");
        end else begin
            $display("FAIL ir_remote_frame_transmitter");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("FAIL ir_remote_frame_transmitter");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/irtx_pkg.sv
rtl/ir_remote_frame_transmitter.sv
rtl/irtx_checker.sv
test/tb_top.sv
